// ===== src/celc_pkg.sv =====
// ----------------------------------------------------------------------------
// celc_pkg
// Shared types and constants of the edge length classifier.
// ----------------------------------------------------------------------------
package celc_pkg;

	// register indexes of the configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ERR_TOL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd2;

	localparam logic [31:0] ERR_TOL_RST = 32'd65536;
	localparam logic [31:0] MIN_LEN_RST = 32'd0;
	localparam logic [31:0] MAX_LEN_RST = 32'hFFFF_FFFF;

	// divider divisor width, square root widths
	localparam int DEN_W     = 32;
	localparam int SQ_ROOT_W = 31;
	localparam int SQ_IN_W   = 2 * SQ_ROOT_W;

	// reciprocals for floor(x/3) and floor(x/5), x below 2^RECIP_SH
	localparam int          RECIP_SH = 34;
	localparam logic [32:0] RECIP_3  = 33'h1_5555_5555;
	localparam logic [31:0] RECIP_5  = 32'hCCCC_CCCC;

	// source of the unclamped target
	typedef enum logic [1:0] {
		SRC_ROOT = 2'd0,
		SRC_ERR  = 2'd1,
		SRC_BIG  = 2'd2
	} target_src_t;

	typedef struct packed {
		target_src_t src;
		logic [31:0] dx;
		logic [31:0] dy;
		logic [31:0] dz;
	} geo_t;

	typedef struct packed {
		logic        too_long;
		logic        too_short;
		logic [31:0] target_length;
	} result_t;

endpackage

// ===== src/celc_if.sv =====
// ----------------------------------------------------------------------------
// celc_if
// Valid/ready channels: edge beats in, classification beats out.
// ----------------------------------------------------------------------------
interface celc_edge_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] first_z;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	logic signed [31:0] second_z;
	logic signed [31:0] first_curvature;
	logic signed [31:0] second_curvature;

	modport source (output valid, first_x, first_y, first_z, second_x, second_y,
		second_z, first_curvature, second_curvature, input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y,
		second_z, first_curvature, second_curvature, output ready);
endinterface

interface celc_class_if;
	logic        valid;
	logic        ready;
	logic        too_long;
	logic        too_short;
	logic [31:0] target_length;

	modport source (output valid, too_long, too_short, target_length, input ready);
	modport sink (input valid, too_long, too_short, target_length, output ready);
endinterface

// ===== src/celc_div.sv =====
// ----------------------------------------------------------------------------
// celc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module celc_div #(
	parameter int DW = 49,
	parameter int SW = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [DW-1:0]                num,
	input  logic [celc_pkg::DEN_W-1:0]   den,
	input  logic [SW-1:0]                side_in,
	output logic                         out_valid,
	output logic [DW-1:0]                quo,
	output logic [SW-1:0]                side_out
);

	localparam int RW = celc_pkg::DEN_W;

	logic          v_s   [DW];
	logic [RW-1:0] rem_s [DW];
	logic [DW-1:0] acc_s [DW];
	logic [RW-1:0] den_s [DW];
	logic [SW-1:0] side_s[DW];

	for (genvar i = 0; i < DW; i++) begin : g_st
		logic          v_i;
		logic [RW-1:0] rem_i;
		logic [DW-1:0] acc_i;
		logic [RW-1:0] den_i;
		logic [SW-1:0] side_i;
		logic [RW:0]   trial;
		logic          ge;
		logic [RW:0]   diff;

		if (i == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = '0;
			assign acc_i  = num;
			assign den_i  = den;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = v_s[i-1];
			assign rem_i  = rem_s[i-1];
			assign acc_i  = acc_s[i-1];
			assign den_i  = den_s[i-1];
			assign side_i = side_s[i-1];
		end

		always_comb begin
			trial = {rem_i, acc_i[DW-1]};
			ge    = trial >= {1'b0, den_i};
			diff  = trial - {1'b0, den_i};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? diff[RW-1:0] : trial[RW-1:0];
				acc_s[i]  <= {acc_i[DW-2:0], ge};
				den_s[i]  <= den_i;
				side_s[i] <= side_i;
			end
		end
	end

	assign out_valid = v_s[DW-1];
	assign quo       = acc_s[DW-1];
	assign side_out  = side_s[DW-1];

endmodule

// ===== src/celc_sqrt.sv =====
// ----------------------------------------------------------------------------
// celc_sqrt
// Pipelined integer square root (floor), one root bit per stage.
// ----------------------------------------------------------------------------
module celc_sqrt #(
	parameter int SW = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [celc_pkg::SQ_IN_W-1:0]    val,
	input  logic [SW-1:0]                   side_in,
	output logic                            out_valid,
	output logic [celc_pkg::SQ_ROOT_W-1:0]  root,
	output logic [SW-1:0]                   side_out
);

	localparam int RB = celc_pkg::SQ_ROOT_W;
	localparam int VW = celc_pkg::SQ_IN_W;
	localparam int RW = RB + 2;

	logic          v_s   [RB];
	logic [RW-1:0] rem_s [RB];
	logic [RB-1:0] root_s[RB];
	logic [VW-1:0] val_s [RB];
	logic [SW-1:0] side_s[RB];

	for (genvar i = 0; i < RB; i++) begin : g_st
		logic          v_i;
		logic [RW-1:0] rem_i;
		logic [RB-1:0] root_i;
		logic [VW-1:0] val_i;
		logic [SW-1:0] side_i;
		logic [RW+1:0] rem2;
		logic [RW+1:0] trial;
		logic [RW+1:0] diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign v_i    = in_valid;
			assign rem_i  = '0;
			assign root_i = '0;
			assign val_i  = val;
			assign side_i = side_in;
		end else begin : g_next
			assign v_i    = v_s[i-1];
			assign rem_i  = rem_s[i-1];
			assign root_i = root_s[i-1];
			assign val_i  = val_s[i-1];
			assign side_i = side_s[i-1];
		end

		always_comb begin
			rem2  = {rem_i, val_i[VW-1 -: 2]};
			trial = {2'b00, root_i, 2'b01};
			ge    = rem2 >= trial;
			diff  = rem2 - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? diff[RW-1:0] : rem2[RW-1:0];
				root_s[i] <= {root_i[RB-2:0], ge};
				val_s[i]  <= {val_i[VW-3:0], 2'b00};
				side_s[i] <= side_i;
			end
		end
	end

	assign out_valid = v_s[RB-1];
	assign root      = root_s[RB-1];
	assign side_out  = side_s[RB-1];

endmodule

// ===== src/celc_skid.sv =====
// ----------------------------------------------------------------------------
// celc_skid
// Two-entry output queue that parts the pipeline from the result channel.
// ----------------------------------------------------------------------------
module celc_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  celc_pkg::result_t push_data,
	output logic              room,
	celc_class_if.source      result
);

	celc_pkg::result_t ent_q [2];
	logic              rd_ptr_q;
	logic              wr_ptr_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign pop  = result.valid && result.ready;
	assign room = (cnt_q != 2'd2) || result.ready;

	assign result.valid         = cnt_q != 2'd0;
	assign result.too_long      = ent_q[rd_ptr_q].too_long;
	assign result.too_short     = ent_q[rd_ptr_q].too_short;
	assign result.target_length = ent_q[rd_ptr_q].target_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= push_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("output queue count out of range");

endmodule

// ===== src/curvature_edge_length_classifier.sv =====
// ----------------------------------------------------------------------------
// curvature_edge_length_classifier
// Curvature driven target edge length and too long / too short test.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake      payload
//   edge_in   in   valid/ready    both endpoints, both curvatures (Q16.16)
//   result    out  valid/ready    too_long, too_short, target_length
//   wr_*      in   wr_en only     wr_index selects register, wr_data value
//
// One beat enters per cycle while the output queue has room. The divider spends
// one stage per quotient bit and the square root one per root bit; around them
// lie the input stage, t select, clamp, two multiply stages, the limit
// correction and the output queue.
// Reset clears every valid bit and the output queue; registers take reset values.
// A stall on result holds the whole pipeline in place; the two-entry queue
// keeps edge_in ready while one finished result waits.
//
module curvature_edge_length_classifier #(
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [celc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [31:0]                      wr_data,
	celc_edge_if.sink                        edge_in,
	celc_class_if.source                     result
);

	localparam int DIV_W  = 33 + FRAC_BITS;
	localparam int SQ_W   = 64 - FRAC_BITS;
	localparam int GEO_W  = $bits(celc_pkg::geo_t);
	localparam int SIDE_W = GEO_W + SQ_W;
	localparam logic [63:0] T_LIM = ((64'd1 << 62) - 64'd1) >> FRAC_BITS;

	// configuration registers
	logic [31:0] err_q, min_q, max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= celc_pkg::ERR_TOL_RST;
			min_q <= celc_pkg::MIN_LEN_RST;
			max_q <= celc_pkg::MAX_LEN_RST;
		end else if (wr_en) begin
			case (wr_index)
				celc_pkg::CFG_ERR_TOL: err_q <= wr_data;
				celc_pkg::CFG_MIN_LEN: min_q <= wr_data;
				celc_pkg::CFG_MAX_LEN: max_q <= wr_data;
				default: ;
			endcase
		end
	end

	// global advance: every stage moves while the output queue can take a beat
	logic en;
	logic accept;
	assign edge_in.ready = en;
	assign accept        = edge_in.valid && en;

	// ---- stage 1: mean curvature, divider operands, err^2, axis distances
	logic signed [32:0] csum;
	logic        [31:0] cmean;
	logic        [32:0] dxa, dxb, dya, dyb, dza, dzb;
	celc_pkg::geo_t     geo_in;

	always_comb begin
		csum  = 33'(edge_in.first_curvature) + 33'(edge_in.second_curvature);
		cmean = csum[32:1];
		dxa   = 33'(edge_in.first_x) - 33'(edge_in.second_x);
		dxb   = 33'(edge_in.second_x) - 33'(edge_in.first_x);
		dya   = 33'(edge_in.first_y) - 33'(edge_in.second_y);
		dyb   = 33'(edge_in.second_y) - 33'(edge_in.first_y);
		dza   = 33'(edge_in.first_z) - 33'(edge_in.second_z);
		dzb   = 33'(edge_in.second_z) - 33'(edge_in.first_z);
		geo_in.dx = dxa[32] ? dxb[31:0] : dxa[31:0];
		geo_in.dy = dya[32] ? dyb[31:0] : dya[31:0];
		geo_in.dz = dza[32] ? dzb[31:0] : dza[31:0];
		// zero mean: unbounded target; negative mean: t never positive
		if (cmean == 32'd0) begin
			geo_in.src = celc_pkg::SRC_BIG;
		end else if (cmean[31]) begin
			geo_in.src = celc_pkg::SRC_ERR;
		end else begin
			geo_in.src = celc_pkg::SRC_ROOT;
		end
	end

	logic             v_s1;
	logic [DIV_W-1:0] num_s1;
	logic [31:0]      den_s1;
	logic [63:0]      sq_s1;
	celc_pkg::geo_t   geo_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= {err_q, 1'b0, {FRAC_BITS{1'b0}}};
			den_s1 <= cmean;
			sq_s1  <= 64'(err_q) * 64'(err_q);
			geo_s1 <= geo_in;
		end
	end

	// ---- divider: q = (2*err << FRAC_BITS) / c
	logic              v_d;
	logic [DIV_W-1:0]  quo_d;
	logic [SIDE_W-1:0] side_d;
	celc_pkg::geo_t    geo_d;
	logic [SQ_W-1:0]   s_d;

	celc_div #(.DW(DIV_W), .SW(SIDE_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s1),
		.num      (num_s1),
		.den      (den_s1),
		.side_in  ({geo_s1, sq_s1[63:FRAC_BITS]}),
		.out_valid(v_d),
		.quo      (quo_d),
		.side_out (side_d)
	);

	assign {geo_d, s_d} = side_d;

	// ---- stage 2: t = q - s, pick err for t <= 0, unbounded for huge t
	logic [63:0]    q64, s64, tval;
	celc_pkg::geo_t geo_t2;

	always_comb begin
		q64    = {{(64-DIV_W){1'b0}}, quo_d};
		s64    = {{FRAC_BITS{1'b0}}, s_d};
		tval   = q64 - s64;
		geo_t2 = geo_d;
		if (geo_d.src == celc_pkg::SRC_ROOT) begin
			if (q64 <= s64) begin
				geo_t2.src = celc_pkg::SRC_ERR;
			end else if (tval > T_LIM) begin
				geo_t2.src = celc_pkg::SRC_BIG;
			end
		end
	end

	logic                         v_s2;
	logic [celc_pkg::SQ_IN_W-1:0] val_s2;
	celc_pkg::geo_t               geo_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s2 <= {tval[61-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
			geo_s2 <= geo_t2;
		end
	end

	// ---- square root of t << FRAC_BITS
	logic                           v_r;
	logic [celc_pkg::SQ_ROOT_W-1:0] root_r;
	logic [GEO_W-1:0]               side_r;
	celc_pkg::geo_t                 geo_r;

	celc_sqrt #(.SW(GEO_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s2),
		.val      (val_s2),
		.side_in  (geo_s2),
		.out_valid(v_r),
		.root     (root_r),
		.side_out (side_r)
	);

	assign geo_r = celc_pkg::geo_t'(side_r);

	// ---- stage 3: raw target and clamp, lower bound first
	logic [32:0] raw;
	logic [31:0] clamped;

	always_comb begin
		case (geo_r.src)
			celc_pkg::SRC_ROOT: raw = {1'b0, root_r, 1'b0};
			celc_pkg::SRC_ERR:  raw = {1'b0, err_q};
			default:            raw = 33'h1_0000_0000;
		endcase
		if (raw < {1'b0, min_q}) begin
			clamped = min_q;
		end else if (raw > {1'b0, max_q}) begin
			clamped = max_q;
		end else begin
			clamped = raw[31:0];
		end
	end

	logic           v_s3;
	logic [31:0]    e_s3;
	celc_pkg::geo_t geo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s3   <= clamped;
			geo_s3 <= geo_r;
		end
	end

	// ---- stage 4: reciprocal estimates of 4e/3, 4e/5 and the squared axes
	logic [33:0] x4;
	logic [66:0] p3;
	logic [65:0] p5;
	assign x4 = {e_s3, 2'b00};
	assign p3 = 67'(x4) * 67'(celc_pkg::RECIP_3);
	assign p5 = 66'(x4) * 66'(celc_pkg::RECIP_5);

	logic        v_s4;
	logic [31:0] e_s4;
	logic [33:0] x_s4;
	logic [32:0] q3_s4;
	logic [31:0] q5_s4;
	logic [63:0] sx_s4, sy_s4, sz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s4  <= e_s3;
			x_s4  <= x4;
			q3_s4 <= p3[66:celc_pkg::RECIP_SH];
			q5_s4 <= p5[65:celc_pkg::RECIP_SH];
			sx_s4 <= 64'(geo_s3.dx) * 64'(geo_s3.dx);
			sy_s4 <= 64'(geo_s3.dy) * 64'(geo_s3.dy);
			sz_s4 <= 64'(geo_s3.dz) * 64'(geo_s3.dz);
		end
	end

	// ---- stage 5: correct the estimates by one, sum the squared length
	logic [34:0] r3, r5;
	assign r3 = {1'b0, x_s4} - ({2'b00, q3_s4} + {1'b0, q3_s4, 1'b0});
	assign r5 = {1'b0, x_s4} - ({3'b000, q5_s4} + {1'b0, q5_s4, 2'b00});

	logic        v_s5;
	logic [31:0] e_s5;
	logic [32:0] a_s5;
	logic [31:0] b_s5;
	logic [65:0] len_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s5   <= e_s4;
			a_s5   <= q3_s4 + 33'(r3 >= 35'd3);
			b_s5   <= q5_s4 + 32'(r5 >= 35'd5);
			len_s5 <= 66'(sx_s4) + 66'(sy_s4) + 66'(sz_s4);
		end
	end

	// ---- stage 6: squared limits
	logic        v_s6;
	logic [31:0] e_s6;
	logic [65:0] aa_s6;
	logic [63:0] bb_s6;
	logic [65:0] len_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s6   <= e_s5;
			aa_s6  <= 66'(a_s5) * 66'(a_s5);
			bb_s6  <= 64'(b_s5) * 64'(b_s5);
			len_s6 <= len_s5;
		end
	end

	// ---- compare and hand the beat to the output queue
	celc_pkg::result_t res;
	logic              push;

	always_comb begin
		res.too_long      = len_s6 > aa_s6;
		res.too_short     = len_s6 < {2'b00, bb_s6};
		res.target_length = e_s6;
	end

	assign push = v_s6 && en;

	celc_skid u_skid (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(res),
		.room     (en),
		.result   (result)
	);

	// clamp keeps the target inside the bounds when they are ordered
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (min_q <= max_q) |-> (e_s3 >= min_q) && (e_s3 <= max_q))
		else $error("target outside clamp bounds");

	// 4e/3 never falls below 4e/5
	a_limits: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> a_s5 >= {1'b0, b_s5}) else $error("upper limit below lower limit");

	// an edge is never both too long and too short
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !(res.too_long && res.too_short)) else $error("conflicting flags");

	// a held pipeline keeps its last stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s6)) else $error("pipeline moved during stall");

endmodule

// ===== dv/curvature_edge_length_classifier_tb.sv =====
// ----------------------------------------------------------------------------
// curvature_edge_length_classifier_tb
// Self-checking bench for the curvature driven edge length classifier.
// Edges are pushed through a valid/ready driver with random gaps. A monitor
// takes the classification beats under random backpressure and compares them
// field by field with the oldest entry of a queue of predicted classifications.
// ----------------------------------------------------------------------------
module curvature_edge_length_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                             FRAC_BITS   = 16;
	localparam logic [celc_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
	localparam logic [63:0]                    UNBOUNDED   = 64'h1_0000_0000;
	localparam logic [63:0]                    ROOT_IN_MAX =
		(64'h4000_0000_0000_0000 - 64'd1) >> FRAC_BITS;
	localparam int                             DRAIN_CYC   = 200;
	localparam int                             HOLD_CYC    = 400;

	typedef struct {
		logic signed [31:0] x0, y0, z0;
		logic signed [31:0] x1, y1, z1;
		logic signed [31:0] k0, k1;
	} edge_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [celc_pkg::CFG_IDX_W-1:0] wr_index = celc_pkg::CFG_ERR_TOL;
	logic [31:0] wr_data = '0;

	celc_edge_if  edge_ch ();
	celc_class_if class_ch ();

	curvature_edge_length_classifier #(.FRAC_BITS(FRAC_BITS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.edge_in  (edge_ch),
		.result   (class_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the configuration registers, updated as each write is driven
	logic [31:0] err_tol = celc_pkg::ERR_TOL_RST;
	logic [31:0] min_len = celc_pkg::MIN_LEN_RST;
	logic [31:0] max_len = celc_pkg::MAX_LEN_RST;

	edge_beat_t        pending_edges[$];
	celc_pkg::result_t predicted_classes[$];

	int  n_fail = 0;
	int  n_sent = 0;
	int  n_checked = 0;
	int  n_long = 0;
	int  n_short = 0;
	bit  steady = 1'b0;     // no idling on either side while set
	bit  hold_out = 1'b0;   // long backpressure on the result side
	bit  hold_go = 1'b0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'h4000_0000_0000_0000;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] span(logic signed [31:0] p, logic signed [31:0] q);
		logic signed [33:0] d;
		d = 34'(p) - 34'(q);
		if (d < 0) d = -d;
		return 64'(d);
	endfunction

	function automatic celc_pkg::result_t classify_edge(edge_beat_t e);
		logic signed [32:0] ksum;
		logic signed [32:0] kmean;
		logic [63:0] err, q, s, t, tgt, lim_a, lim_b, dx, dy, dz;
		logic [127:0] len2;
		celc_pkg::result_t r;
		ksum = 33'(e.k0) + 33'(e.k1);
		kmean = ksum >>> 1;
		err = {32'd0, err_tol};
		// zero mean curvature means a flat patch: unbounded target
		if (kmean == 0) begin
			tgt = UNBOUNDED;
		end else if (kmean < 0) begin
			tgt = err;
		end else begin
			q = ((err * 64'd2) << FRAC_BITS) / 64'(kmean);
			s = (err * err) >> FRAC_BITS;
			if (q <= s) begin
				tgt = err;
			end else begin
				t = q - s;
				if (t > ROOT_IN_MAX) tgt = UNBOUNDED;
				else tgt = 64'd2 * floor_root(t << FRAC_BITS);
			end
		end
		// lower bound wins when the bounds cross
		if (tgt < {32'd0, min_len}) tgt = {32'd0, min_len};
		else if (tgt > {32'd0, max_len}) tgt = {32'd0, max_len};
		dx = span(e.x0, e.x1);
		dy = span(e.y0, e.y1);
		dz = span(e.z0, e.z1);
		len2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
		lim_a = (64'd4 * tgt) / 64'd3;
		lim_b = (64'd4 * tgt) / 64'd5;
		r.too_long = len2 > 128'(lim_a) * 128'(lim_a);
		r.too_short = len2 < 128'(lim_b) * 128'(lim_b);
		r.target_length = tgt[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s, got %h, expected %h", $time, what, got, want);
		n_fail++;
	endtask

	// ------------------------------------------------------------------
	// Driver: offer the next pending edge, drop valid on a random idle cycle
	// ------------------------------------------------------------------
	initial begin
		edge_ch.valid = 1'b0;
		edge_ch.first_x = '0;
		edge_ch.first_y = '0;
		edge_ch.first_z = '0;
		edge_ch.second_x = '0;
		edge_ch.second_y = '0;
		edge_ch.second_z = '0;
		edge_ch.first_curvature = '0;
		edge_ch.second_curvature = '0;
		class_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		edge_beat_t nb;
		edge_beat_t acc;
		if (!arst_n) begin
			edge_ch.valid <= 1'b0;
		end else begin
			// predict at acceptance, against the registers in force now
			if (edge_ch.valid && edge_ch.ready) begin
				acc.x0 = edge_ch.first_x;
				acc.y0 = edge_ch.first_y;
				acc.z0 = edge_ch.first_z;
				acc.x1 = edge_ch.second_x;
				acc.y1 = edge_ch.second_y;
				acc.z1 = edge_ch.second_z;
				acc.k0 = edge_ch.first_curvature;
				acc.k1 = edge_ch.second_curvature;
				predicted_classes.push_back(classify_edge(acc));
				n_sent++;
			end
			if (!edge_ch.valid || edge_ch.ready) begin
				if (pending_edges.size() != 0 &&
						(steady || $urandom_range(99) >= 35)) begin
					nb = pending_edges.pop_front();
					edge_ch.valid <= 1'b1;
					edge_ch.first_x <= nb.x0;
					edge_ch.first_y <= nb.y0;
					edge_ch.first_z <= nb.z0;
					edge_ch.second_x <= nb.x1;
					edge_ch.second_y <= nb.y1;
					edge_ch.second_z <= nb.z1;
					edge_ch.first_curvature <= nb.k0;
					edge_ch.second_curvature <= nb.k1;
				end else begin
					edge_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: random backpressure, compare each beat with the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		celc_pkg::result_t want;
		if (!arst_n) begin
			class_ch.ready <= 1'b0;
		end else begin
			if (class_ch.valid && class_ch.ready) begin
				if (predicted_classes.size() == 0) begin
					$display("%0t: classification beat with nothing predicted", $time);
					n_fail++;
				end else begin
					want = predicted_classes.pop_front();
					n_checked++;
					if (class_ch.too_long) n_long++;
					if (class_ch.too_short) n_short++;
					if (class_ch.too_long !== want.too_long)
						report_mismatch("too_long", 32'(class_ch.too_long), 32'(want.too_long));
					if (class_ch.too_short !== want.too_short)
						report_mismatch("too_short", 32'(class_ch.too_short),
							32'(want.too_short));
					if (class_ch.target_length !== want.target_length)
						report_mismatch("target_length", class_ch.target_length,
							want.target_length);
				end
			end
			class_ch.ready <= !hold_out && (steady || $urandom_range(99) >= 35);
		end
	end

	// long hold-off on the result side, counted here so the sender keeps going
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (HOLD_CYC) @(posedge clk);
		hold_out <= 1'b0;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_edge(logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
			logic [31:0] x1, logic [31:0] y1, logic [31:0] z1,
			logic [31:0] k0, logic [31:0] k1);
		edge_beat_t e;
		e.x0 = x0; e.y0 = y0; e.z0 = z0;
		e.x1 = x1; e.y1 = y1; e.z1 = z1;
		e.k0 = k0; e.k1 = k1;
		pending_edges.push_back(e);
	endtask

	// signed offset whose magnitude lies below 2^(k+1) for a random k
	function automatic logic [31:0] offset_of(logic [31:0] p);
		int unsigned k;
		logic [31:0] m;
		k = $urandom_range(31);
		m = (k == 31) ? $urandom : ($urandom & ((32'd1 << (k + 1)) - 1));
		if ($urandom_range(1)) m = -m;
		return p + m;
	endfunction

	task automatic add_random_edge();
		logic [31:0] x0, y0, z0, k0, k1;
		int unsigned mode;
		x0 = $urandom; y0 = $urandom; z0 = $urandom;
		mode = $urandom_range(9);
		case (mode)
			0, 1, 2, 3: begin
				// ordinary surface: positive curvature, at most 16.0 in Q16.16
				k0 = $urandom_range(32'h0010_0000, 1);
				k1 = $urandom_range(32'h0010_0000, 1);
			end
			4: begin
				// flat on average: sum of zero or one
				k0 = $urandom;
				k1 = -k0 + $urandom_range(1);
			end
			5: begin
				k0 = -$urandom_range(32'h0010_0000, 0);
				k1 = -$urandom_range(32'h0010_0000, 0);
			end
			6: begin
				k0 = $urandom_range(3);
				k1 = $urandom_range(3);
			end
			default: begin
				k0 = $urandom;
				k1 = $urandom;
			end
		endcase
		if ($urandom_range(9) == 0)
			add_edge(x0, y0, z0, $urandom, $urandom, $urandom, k0, k1);
		else
			add_edge(x0, y0, z0, offset_of(x0), offset_of(y0), offset_of(z0), k0, k1);
	endtask

	task automatic wait_idle();
		while (pending_edges.size() != 0 || edge_ch.valid || predicted_classes.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_regs(logic [31:0] err, logic [31:0] lo, logic [31:0] hi);
		wait_idle();
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= celc_pkg::CFG_ERR_TOL;
		wr_data <= err;
		err_tol = err;
		@(posedge clk);
		wr_index <= celc_pkg::CFG_MIN_LEN;
		wr_data <= lo;
		min_len = lo;
		@(posedge clk);
		wr_index <= celc_pkg::CFG_MAX_LEN;
		wr_data <= hi;
		max_len = hi;
		@(posedge clk);
		// unmapped index must leave every register alone
		wr_index <= CFG_UNUSED;
		wr_data <= $urandom;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned err, lo, hi;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed edges under reset register values
		add_edge(0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000);
		add_edge(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_edge(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 32'h8000_0000, 32'h8000_0000);
		add_edge(0, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 32'hFFFF_0000);
		add_edge(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0000_0001, 32'h0000_0000);
		add_edge(0, 0, 0, 32'h0000_8000, 0, 0, 32'hFFFF_FFFF, 32'h0000_0000);
		add_edge(0, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 32'h0001_0000);
		add_edge(0, 0, 0, 32'h0002_AAAB, 0, 0, 32'h0001_0000, 32'h0001_0000);
		add_edge(0, 0, 0, 32'h0001_999A, 0, 0, 32'h0001_0000, 32'h0001_0000);
		add_edge(0, 0, 0, 0, 0, 0, 32'h0000_0001, 32'h0000_0001);
		add_edge(5, 7, 9, 5, 7, 9, 32'hFFFF_FFFF, 32'h8000_0000);
		add_edge(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0040_0000, 32'h0040_0000);
		wait_idle();

		// zero tolerance and a closed clamp window
		write_regs(32'd0, 32'd0, 32'd0);
		add_edge(0, 0, 0, 1, 0, 0, 32'h0001_0000, 32'h0001_0000);
		add_edge(0, 0, 0, 0, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF);
		add_edge(0, 0, 0, 0, 0, 0, 32'h0000_0001, 32'h0000_0000);

		// huge tolerance, crossed bounds where the lower bound wins
		write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		add_edge(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h0000_0001, 32'h0000_0001);
		add_edge(0, 0, 0, 0, 0, 0, 32'hFFFF_0000, 32'hFFFF_0000);
		write_regs(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		add_edge(0, 0, 0, 32'h0100_0000, 0, 0, 32'h0000_0002, 32'h0000_0001);
		add_edge(0, 0, 0, 32'h0100_0000, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		add_edge(0, 0, 0, 32'h0100_0000, 0, 0, 32'h8000_0000, 32'hFFFF_FFFF);

		// random phases, each under its own register setting
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin err = 32'h0001_0000; lo = 0; hi = 32'hFFFF_FFFF; end
				1: begin
					err = $urandom_range(32'h0010_0000, 32'h0000_1000);
					lo = $urandom_range(32'h0000_4000);
					hi = $urandom_range(32'hFFFF_FFFF, 32'h0004_0000);
				end
				2: begin err = $urandom; lo = $urandom; hi = $urandom; end
				3: begin err = $urandom_range(32'h0004_0000, 32'h0000_4000); lo = 0;
					hi = 32'hFFFF_FFFF; end
				4: begin err = $urandom; lo = $urandom_range(32'h0001_0000); hi = $urandom; end
				default: begin err = $urandom_range(32'h0002_0000, 32'h0000_8000);
					lo = $urandom_range(32'h0000_8000); hi = 32'hFFFF_FFFF; end
			endcase
			write_regs(err, lo, hi);
			for (int i = 0; i < 250; i++) add_random_edge();
			// fill the pipeline against a stalled result side
			if (ph == 1) hold_go = 1'b1;
			// a stretch where neither side idles
			steady = (ph == 3);
		end

		wait_idle();
		steady = 1'b0;
		repeat (DRAIN_CYC) @(posedge clk);
		if (predicted_classes.size() != 0) begin
			$display("%0d predicted classifications never arrived", predicted_classes.size());
			n_fail++;
		end
		$display("Sent %0d edges, checked %0d classifications (%0d long, %0d short)",
			n_sent, n_checked, n_long, n_short);
		$display("Covered flat, concave and huge-target edges and crossed clamp bounds");
		if (n_fail == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout with %0d edges pending", pending_edges.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
